### rtl/mfs_pkg.sv
`default_nettype none

package mfs_pkg;

  // Kind codes of an input word.
  localparam logic [2:0] KIND_RATE   = 3'd0;
  localparam logic [2:0] KIND_LOAD_P = 3'd1;
  localparam logic [2:0] KIND_LOAD_Q = 3'd2;
  localparam logic [2:0] KIND_SNAP   = 3'd3;
  localparam logic [2:0] KIND_READ_P = 3'd4;
  localparam logic [2:0] KIND_READ_Q = 3'd5;

  // Configuration register indexes.
  localparam logic [1:0] REG_LEARN  = 2'd0;
  localparam logic [1:0] REG_REG    = 2'd1;
  localparam logic [1:0] REG_P_BASE = 2'd2;
  localparam logic [1:0] REG_Q_BASE = 2'd3;

  // Reset values of the configuration registers.
  localparam logic [15:0] LEARN_RESET = 16'd66;
  localparam logic [15:0] REG_RESET   = 16'd3277;

  // Clamp limits, +/-0.5 in Q1.15.
  localparam logic signed [27:0] HALF_POS = 28'sd16384;
  localparam logic signed [27:0] HALF_NEG = -28'sd16384;

  typedef struct packed {
    logic [2:0]         kind;
    logic [23:0]        user_id;
    logic [23:0]        item_id;
    logic [5:0]         factor_index;
    logic [15:0]        rating;
    logic signed [15:0] load_value;
  } mfs_in_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic               status;
  } mfs_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DOT,
    ST_ERR,
    ST_UPD,
    ST_SNAP,
    ST_RD,
    ST_DONE
  } mfs_state_t;

  // Clamp a widened factor value to the range [-0.5, 0.5].
  function automatic logic signed [15:0] clamp_half(input logic signed [27:0] v);
    logic signed [27:0] c;
    begin
      if (v > HALF_POS) begin
        c = HALF_POS;
      end else if (v < HALF_NEG) begin
        c = HALF_NEG;
      end else begin
        c = v;
      end
      clamp_half = c[15:0];
    end
  endfunction

endpackage

`default_nettype wire

### rtl/mf_sgd_factor_update.sv
`default_nettype none

// Channel   Direction  Handshake            Word
// in_       input      in_valid/in_ready    mfs_in_t: kind, ids, index, rating, load value
// out_      output     out_valid/out_ready  mfs_out_t: value, status
// cfg_      input      cfg_we               cfg_index selects the register, cfg_data
//
// A rating makes two passes over the row, each reading one element of every
// factor store per cycle, then drains the pipeline before its result.
// A snapshot sweeps the live stores one entry per cycle into the snapshot
// stores, over 2**AW addresses where AW is the wider store address.
// Loads, reads and flagged words go from EXEC to DONE, a read by way of RD.
// Reset is synchronous; the factor stores are not cleared.
// One word is in work at a time; a finished result waits in the output register.
module mf_sgd_factor_update #(
  parameter int FACTORS   = 16,
  parameter int USER_ROWS = 1024,
  parameter int ITEM_ROWS = 1024
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire mfs_pkg::mfs_in_t in_data,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output mfs_pkg::mfs_out_t     out_data,
  input  wire logic             cfg_we,
  input  wire logic [1:0]       cfg_index,
  input  wire logic [23:0]      cfg_data
);

  import mfs_pkg::*;

  localparam int FB  = (FACTORS > 1) ? $clog2(FACTORS) : 1;
  localparam int KW  = FB + 1;
  localparam int AWP = $clog2(USER_ROWS) + FB;
  localparam int AWQ = $clog2(ITEM_ROWS) + FB;
  localparam int AWS = (AWP > AWQ) ? AWP : AWQ;
  localparam logic [KW-1:0]  KEND  = KW'(FACTORS);
  localparam logic [23:0]    UROWS = 24'(USER_ROWS);
  localparam logic [23:0]    IROWS = 24'(ITEM_ROWS);
  localparam logic [6:0]     FNUM  = 7'(FACTORS);
  localparam logic [AWS:0]   SEND  = (AWS+1)'(2**AWS);
  localparam logic [AWS:0]   PEND  = (AWS+1)'(2**AWP);
  localparam logic [AWS:0]   QEND  = (AWS+1)'(2**AWQ);

  // Configuration registers.
  logic [15:0] learn_r, regw_r;
  logic [23:0] p_base_r, q_base_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      learn_r  <= LEARN_RESET;
      regw_r   <= REG_RESET;
      p_base_r <= '0;
      q_base_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LEARN:  learn_r  <= cfg_data[15:0];
        REG_REG:    regw_r   <= cfg_data[15:0];
        REG_P_BASE: p_base_r <= cfg_data;
        REG_Q_BASE: q_base_r <= cfg_data;
        default:    ;
      endcase
    end
  end

  mfs_state_t state_r, state_nxt;

  // Latched word and row checks.
  logic [2:0]         kind_r;
  logic [5:0]         fidx_r;
  logic signed [15:0] lval_r;
  logic [15:0]        pr_r, qr_r;
  logic               p_ok_r, q_ok_r;
  logic [23:0]        poff, qoff;
  logic               p_ok, q_ok, f_ok, in_fire;

  assign in_ready = (state_r == ST_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign poff     = in_data.user_id - p_base_r;
  assign qoff     = in_data.item_id - q_base_r;
  assign p_ok     = (in_data.user_id >= p_base_r) && (poff < UROWS);
  assign q_ok     = (in_data.item_id >= q_base_r) && (qoff < IROWS);
  assign f_ok     = ({1'b0, fidx_r} < FNUM);

  // Sequencer and pipeline registers.
  logic [KW-1:0]      k_r;
  logic [AWS:0]       sw_r;
  logic               d1_v_r, d2_v_r;
  logic [FB-1:0]      d1_k_r;
  logic signed [31:0] prod_r;
  logic signed [39:0] acc_r;
  logic signed [24:0] err_r;
  logic               u1_v_r, u2_v_r, u3_v_r, u4_v_r;
  logic [FB-1:0]      u1_k_r, u2_k_r, u3_k_r, u4_k_r;
  logic signed [40:0] ep_r, eq_r;
  logic signed [32:0] rp_r, rq_r;
  logic signed [42:0] tp_r, tq_r;
  logic [36:0]        plo_r, qlo_r;
  logic signed [38:0] phi_r, qhi_r;
  logic signed [15:0] lp2_r, lq2_r, lp3_r, lq3_r, lp4_r, lq4_r;
  logic               c1_v_r;
  logic [AWS:0]       c1_a_r;
  logic signed [31:0] res_val_r;
  logic               res_st_r;
  logic               out_valid_r;
  mfs_out_t           out_data_r;

  // Memory ports.
  logic [AWP-1:0] lp_ra, sp_ra, lp_wa, sp_wa;
  logic [AWQ-1:0] lq_ra, sq_ra, lq_wa, sq_wa;
  logic           lp_we, sp_we, lq_we, sq_we;
  logic [15:0]    lp_wd, sp_wd, lq_wd, sq_wd;
  logic [15:0]    lp_rd, sp_rd, lq_rd, sq_rd;
  logic signed [15:0] lp_s, lq_s, sp_s, sq_s, csp, csq;

  assign lp_s = lp_rd;
  assign lq_s = lq_rd;
  assign sp_s = sp_rd;
  assign sq_s = sq_rd;
  assign csp  = clamp_half(28'(sp_s));
  assign csq  = clamp_half(28'(sq_s));

  mfs_ram #(.WIDTH(16), .DEPTH(2**AWP)) u_live_p (
    .clk(clk), .we(lp_we), .waddr(lp_wa), .wdata(lp_wd), .raddr(lp_ra), .rdata(lp_rd)
  );
  mfs_ram #(.WIDTH(16), .DEPTH(2**AWP)) u_snap_p (
    .clk(clk), .we(sp_we), .waddr(sp_wa), .wdata(sp_wd), .raddr(sp_ra), .rdata(sp_rd)
  );
  mfs_ram #(.WIDTH(16), .DEPTH(2**AWQ)) u_live_q (
    .clk(clk), .we(lq_we), .waddr(lq_wa), .wdata(lq_wd), .raddr(lq_ra), .rdata(lq_rd)
  );
  mfs_ram #(.WIDTH(16), .DEPTH(2**AWQ)) u_snap_q (
    .clk(clk), .we(sq_we), .waddr(sq_wa), .wdata(sq_wd), .raddr(sq_ra), .rdata(sq_rd)
  );

  // Update arithmetic of the last stage.
  logic signed [63:0] pprod, qprod;
  logic signed [27:0] pnew, qnew;
  logic               issue, dot_done, upd_done, snap_done;

  assign pprod = (64'(phi_r) <<< 21) + $signed({27'd0, plo_r}) + 64'sd2147483648;
  assign qprod = (64'(qhi_r) <<< 21) + $signed({27'd0, qlo_r}) + 64'sd2147483648;
  assign pnew  = 28'(lp4_r) + pprod[59:32];
  assign qnew  = 28'(lq4_r) + qprod[59:32];

  assign issue     = (k_r != KEND);
  assign dot_done  = !issue && !d1_v_r && !d2_v_r;
  assign upd_done  = !issue && !u1_v_r && !u2_v_r && !u3_v_r && !u4_v_r;
  assign snap_done = (sw_r == SEND) && !c1_v_r;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        case (kind_r)
          KIND_RATE:   state_nxt = (p_ok_r && q_ok_r) ? ST_DOT : ST_DONE;
          KIND_READ_P: state_nxt = (p_ok_r && f_ok) ? ST_RD : ST_DONE;
          KIND_READ_Q: state_nxt = (q_ok_r && f_ok) ? ST_RD : ST_DONE;
          KIND_SNAP:   state_nxt = ST_SNAP;
          default:     state_nxt = ST_DONE;
        endcase
      end
      ST_DOT:  if (dot_done) state_nxt = ST_ERR;
      ST_ERR:  state_nxt = ST_UPD;
      ST_UPD:  if (upd_done) state_nxt = ST_DONE;
      ST_SNAP: if (snap_done) state_nxt = ST_DONE;
      ST_RD:   state_nxt = ST_DONE;
      ST_DONE: if (!out_valid_r || out_ready) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Memory control.
  always_comb begin
    lp_ra = AWP'({pr_r, k_r[FB-1:0]});
    sp_ra = AWP'({pr_r, k_r[FB-1:0]});
    lq_ra = AWQ'({qr_r, k_r[FB-1:0]});
    sq_ra = AWQ'({qr_r, k_r[FB-1:0]});
    lp_we = 1'b0;
    sp_we = 1'b0;
    lq_we = 1'b0;
    sq_we = 1'b0;
    lp_wa = AWP'({pr_r, u4_k_r});
    lq_wa = AWQ'({qr_r, u4_k_r});
    sp_wa = AWP'({pr_r, d1_k_r});
    sq_wa = AWQ'({qr_r, d1_k_r});
    lp_wd = clamp_half(pnew);
    lq_wd = clamp_half(qnew);
    sp_wd = csp;
    sq_wd = csq;
    case (state_r)
      ST_EXEC: begin
        lp_ra = AWP'({pr_r, fidx_r[FB-1:0]});
        lq_ra = AWQ'({qr_r, fidx_r[FB-1:0]});
        lp_wa = AWP'({pr_r, fidx_r[FB-1:0]});
        sp_wa = AWP'({pr_r, fidx_r[FB-1:0]});
        lq_wa = AWQ'({qr_r, fidx_r[FB-1:0]});
        sq_wa = AWQ'({qr_r, fidx_r[FB-1:0]});
        lp_wd = lval_r;
        sp_wd = lval_r;
        lq_wd = lval_r;
        sq_wd = lval_r;
        if (kind_r == KIND_LOAD_P && p_ok_r && f_ok) begin
          lp_we = 1'b1;
          sp_we = 1'b1;
        end
        if (kind_r == KIND_LOAD_Q && q_ok_r && f_ok) begin
          lq_we = 1'b1;
          sq_we = 1'b1;
        end
      end
      ST_DOT: begin
        sp_we = d1_v_r;
        sq_we = d1_v_r;
      end
      ST_UPD: begin
        lp_we = u4_v_r;
        lq_we = u4_v_r;
      end
      ST_SNAP: begin
        lp_ra = AWP'(sw_r);
        lq_ra = AWQ'(sw_r);
        sp_wa = AWP'(c1_a_r);
        sq_wa = AWQ'(c1_a_r);
        sp_wd = lp_rd;
        sq_wd = lq_rd;
        sp_we = c1_v_r && (c1_a_r < PEND);
        sq_we = c1_v_r && (c1_a_r < QEND);
      end
      default: ;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      d1_v_r      <= 1'b0;
      d2_v_r      <= 1'b0;
      u1_v_r      <= 1'b0;
      u2_v_r      <= 1'b0;
      u3_v_r      <= 1'b0;
      u4_v_r      <= 1'b0;
      c1_v_r      <= 1'b0;
      k_r         <= KEND;
      sw_r        <= SEND;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_DONE && (!out_valid_r || out_ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (state_r == ST_EXEC || state_r == ST_ERR) begin
        k_r <= '0;
      end else if ((state_r == ST_DOT || state_r == ST_UPD) && issue) begin
        k_r <= k_r + 1'b1;
      end
      if (state_r == ST_EXEC) begin
        sw_r <= '0;
      end else if (state_r == ST_SNAP && sw_r != SEND) begin
        sw_r <= sw_r + 1'b1;
      end
      d1_v_r <= (state_r == ST_DOT) && issue;
      d2_v_r <= d1_v_r;
      u1_v_r <= (state_r == ST_UPD) && issue;
      u2_v_r <= u1_v_r;
      u3_v_r <= u2_v_r;
      u4_v_r <= u3_v_r;
      c1_v_r <= (state_r == ST_SNAP) && (sw_r != SEND);
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      kind_r <= in_data.kind;
      fidx_r <= in_data.factor_index;
      lval_r <= in_data.load_value;
      pr_r   <= poff[15:0];
      qr_r   <= qoff[15:0];
      p_ok_r <= p_ok;
      q_ok_r <= q_ok;
      acc_r  <= $signed({9'd0, in_data.rating, 15'd0});
    end
    if (state_r == ST_EXEC) begin
      res_val_r <= '0;
      case (kind_r)
        KIND_RATE:   res_st_r <= !(p_ok_r && q_ok_r);
        KIND_LOAD_P: res_st_r <= !(p_ok_r && f_ok);
        KIND_READ_P: res_st_r <= !(p_ok_r && f_ok);
        KIND_LOAD_Q: res_st_r <= !(q_ok_r && f_ok);
        KIND_READ_Q: res_st_r <= !(q_ok_r && f_ok);
        KIND_SNAP:   res_st_r <= 1'b0;
        default:     res_st_r <= 1'b1;
      endcase
    end
    if (state_r == ST_RD) begin
      res_val_r <= (kind_r == KIND_READ_P) ? 32'(lp_s) : 32'(lq_s);
    end
    // Dot pass: clamp the snapshot pair, multiply, accumulate.
    d1_k_r <= k_r[FB-1:0];
    prod_r <= csp * csq;
    if (state_r == ST_DOT && d2_v_r) begin
      acc_r <= acc_r - 40'(prod_r);
    end
    if (state_r == ST_ERR) begin
      err_r     <= 25'((acc_r + 40'sd16384) >>> 15);
      res_val_r <= 32'(25'((acc_r + 40'sd16384) >>> 15));
    end
    // Update pass, stage one: products with the error and the weight.
    u1_k_r <= k_r[FB-1:0];
    u2_k_r <= u1_k_r;
    ep_r   <= err_r * sq_s;
    eq_r   <= err_r * sp_s;
    rp_r   <= $signed({1'b0, regw_r}) * sp_s;
    rq_r   <= $signed({1'b0, regw_r}) * sq_s;
    lp2_r  <= lp_s;
    lq2_r  <= lq_s;
    // Stage two: the update term.
    u3_k_r <= u2_k_r;
    tp_r   <= (43'(ep_r) <<< 1) - 43'(rp_r);
    tq_r   <= (43'(eq_r) <<< 1) - 43'(rq_r);
    lp3_r  <= lp2_r;
    lq3_r  <= lq2_r;
    // Stage three: learning rate times the term, in two partial products.
    u4_k_r <= u3_k_r;
    plo_r  <= {5'd0, learn_r} * {16'd0, tp_r[20:0]};
    qlo_r  <= {5'd0, learn_r} * {16'd0, tq_r[20:0]};
    phi_r  <= $signed({1'b0, learn_r}) * $signed(tp_r[42:21]);
    qhi_r  <= $signed({1'b0, learn_r}) * $signed(tq_r[42:21]);
    lp4_r  <= lp3_r;
    lq4_r  <= lq3_r;
    // Snapshot copy address is sw_r registered, so it follows the read address into the next cycle.
    c1_a_r <= sw_r;
    if (state_r == ST_DONE && (!out_valid_r || out_ready)) begin
      out_data_r.value  <= res_val_r;
      out_data_r.status <= res_st_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

### rtl/mfs_ram.sv
`default_nettype none

module mfs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire
